@@ sv/tcc_pkg.sv @@
// Shared types and constants for the text console cursor control block.
`timescale 1ns / 1ps
`default_nettype none
package tcc_pkg;

  // Character codes handled by the cursor logic
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Input actions
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_HOME = 1'b1;

  // Result commands
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 1'b1;

  localparam logic [7:0] TEXT_COLUMNS_RESET = 8'd75;
  localparam logic [7:0] TEXT_ROWS_RESET    = 8'd35;

  localparam int unsigned TAB_STOP_DEFAULT = 8;

  // Result budget per input item
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_SCROLL
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic home;
    logic step;
    logic load_draw;
    logic load_scroll;
    logic out_last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic draw;
    logic scroll;
    logic n_one;
    logic n_zero;
    logic cnt_lim;
    logic slot_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/tcc_intf.sv @@
// Handshake channel interfaces: character input, cell command output, configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface tcc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink (input valid, input action, input char_code, output ready);
endinterface

interface tcc_out_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] cell_column;
  logic [7:0] cell_row;
  logic [7:0] glyph_code;
  logic       last;

  modport source (output valid, output command, output cell_column, output cell_row,
                  output glyph_code, output last, input ready);
  modport sink (input valid, input command, input cell_column, input cell_row,
                input glyph_code, input last, output ready);
endinterface

interface tcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/tcc_ctrl.sv @@
// Sequencer for the cursor control block: steps spaces, draws and scrolls.
`timescale 1ns / 1ps
`default_nettype none
module tcc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_action_i,
  output      logic               in_ready_o,
  input  wire tcc_pkg::dp_stat_t  stat_i,
  output      tcc_pkg::ctrl_cmd_t cmd_o
);
  import tcc_pkg::*;

  state_e state_q, state_d;
  logic   draw_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    draw_last  = !stat_i.scroll && (stat_i.n_one || stat_i.cnt_lim);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ACT_HOME) begin
            cmd_o.home = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (stat_i.draw) begin
          // hold until the output register can take the draw beat
          if (stat_i.slot_free) begin
            cmd_o.step      = 1'b1;
            cmd_o.load_draw = 1'b1;
            cmd_o.out_last  = draw_last;
            if (stat_i.scroll) begin
              state_d = ST_SCROLL;
            end else if (draw_last) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          // cursor move only: no draw beat
          cmd_o.step = 1'b1;
          state_d    = stat_i.scroll ? ST_SCROLL : ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (stat_i.slot_free) begin
          cmd_o.load_scroll = 1'b1;
          cmd_o.out_last    = stat_i.n_zero || stat_i.cnt_lim;
          state_d           = (stat_i.n_zero || stat_i.cnt_lim) ? ST_IDLE : ST_STEP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/tcc_dp.sv @@
// Datapath: size registers, cursor, tab counters and the result output register.
`timescale 1ns / 1ps
`default_nettype none
module tcc_dp #(
  parameter int unsigned TAB_STOP = tcc_pkg::TAB_STOP_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i,
  input  wire logic [7:0]                     in_char_code_i,
  input  wire tcc_pkg::ctrl_cmd_t             cmd_i,
  output      tcc_pkg::dp_stat_t              stat_o,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic                           out_command_o,
  output      logic [7:0]                     out_cell_column_o,
  output      logic [7:0]                     out_cell_row_o,
  output      logic [7:0]                     out_glyph_code_o,
  output      logic                           out_last_o
);
  import tcc_pkg::*;

  localparam int unsigned N_W = $clog2(TAB_STOP + 1);

  typedef logic [255:0][N_W-1:0] space_tab_t;

  // Spaces to the next tab stop for every column, built without division
  function automatic space_tab_t build_space_tab();
    space_tab_t  tab;
    int unsigned r;
    tab = '0;
    r   = 0;
    for (int unsigned i = 0; i < 256; i++) begin
      tab[i] = N_W'(TAB_STOP - r);
      r      = (r == TAB_STOP - 1) ? 0 : r + 1;
    end
    return tab;
  endfunction

  localparam space_tab_t SPACE_TAB = build_space_tab();

  logic [7:0]     cols_q, rows_q;
  logic [7:0]     col_q, row_q;
  logic [7:0]     col_d, row_d;
  logic [7:0]     ch_q;
  logic [N_W-1:0] n_q;
  logic [CNT_W-1:0] cnt_q;

  logic           out_valid_q;
  logic           out_command_q;
  logic [7:0]     out_col_q, out_row_q, out_glyph_q;
  logic           out_last_q;

  logic [7:0]     eff_cols, eff_rows;
  logic [8:0]     col_nx, row_nx;
  logic           draw, scroll, slot_free, load;

  assign eff_cols = (cols_q == 8'd0) ? 8'd1 : cols_q;
  assign eff_rows = (rows_q == 8'd0) ? 8'd1 : rows_q;

  // Cursor update for one character, then wrap and clamp
  always_comb begin
    draw   = 1'b0;
    scroll = 1'b0;
    col_nx = {1'b0, col_q};
    row_nx = {1'b0, row_q};
    case (ch_q)
      CH_CR: begin
        col_nx = 9'd0;
      end
      CH_LF: begin
        col_nx = 9'd0;
        row_nx = {1'b0, row_q} + 9'd1;
      end
      CH_BS: begin
        if (col_q != 8'd0) begin
          col_nx = {1'b0, col_q} - 9'd1;
        end
      end
      default: begin
        draw   = 1'b1;
        col_nx = {1'b0, col_q} + 9'd1;
      end
    endcase
    if (col_nx >= {1'b0, eff_cols}) begin
      col_nx = 9'd0;
      row_nx = row_nx + 9'd1;
    end
    col_d = col_nx[7:0];
    row_d = row_nx[7:0];
    if (row_nx >= {1'b0, eff_rows}) begin
      row_d  = eff_rows - 8'd1;
      scroll = 1'b1;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign load      = cmd_i.load_draw || cmd_i.load_scroll;

  assign stat_o.draw      = draw;
  assign stat_o.scroll    = scroll;
  assign stat_o.n_one     = (n_q == N_W'(1));
  assign stat_o.n_zero    = (n_q == '0);
  assign stat_o.cnt_lim   = (cnt_q >= CNT_W'(MAX_RESULTS - 2));
  assign stat_o.slot_free = slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= TEXT_COLUMNS_RESET;
      rows_q      <= TEXT_ROWS_RESET;
      col_q       <= 8'd0;
      row_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TEXT_COLUMNS: cols_q <= cfg_data_i;
          REG_TEXT_ROWS:    rows_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.home) begin
        col_q <= 8'd0;
        row_q <= 8'd0;
      end else if (cmd_i.step) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item registers and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      // a tab runs as a series of spaces
      if (in_char_code_i == CH_TAB) begin
        ch_q <= CH_SPACE;
        n_q  <= SPACE_TAB[col_q];
      end else begin
        ch_q <= in_char_code_i;
        n_q  <= N_W'(1);
      end
      cnt_q <= '0;
    end else begin
      if (cmd_i.step) begin
        n_q <= n_q - N_W'(1);
      end
      if (load) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
    if (cmd_i.load_draw) begin
      out_command_q <= CMD_DRAW;
      out_col_q     <= col_q;
      out_row_q     <= row_q;
      out_glyph_q   <= ch_q;
      out_last_q    <= cmd_i.out_last;
    end else if (cmd_i.load_scroll) begin
      out_command_q <= CMD_SCROLL;
      out_col_q     <= 8'd0;
      out_row_q     <= 8'd0;
      out_glyph_q   <= 8'd0;
      out_last_q    <= cmd_i.out_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_command_o     = out_command_q;
  assign out_cell_column_o = out_col_q;
  assign out_cell_row_o    = out_row_q;
  assign out_glyph_code_o  = out_glyph_q;
  assign out_last_o        = out_last_q;

endmodule
`default_nettype wire

@@ sv/text_console_cursor_control.sv @@
// Top level of the text console cursor control block.
//
// Usage: in_if carries one beat per character (action = put) or a home
// action; out_if carries draw-cell and scroll beats, with last set on the
// final beat caused by an input. cfg_if writes text_columns (index 0) and
// text_rows (index 1); it is always ready and should be used while idle.
// A printable character is accepted in the idle state; its draw beat is loaded
// into the output register from the step state, and a following scroll beat
// from the scroll state. A tab runs through the step state once per space, with
// a scroll beat after each space that scrolls; home is handled in the idle state.
// The sequencer issues one result beat per cycle into the single output register
// unless the receiver stalls; a new input is accepted only back in idle.
// Control codes that move the cursor without scrolling give no beats.
// Reset: cursor at row 0, column 0; 75 columns and 35 rows.
// Receiver stall: the output register holds its beat and the sequencer
// waits; a new input is still accepted while the last beat waits.
`timescale 1ns / 1ps
`default_nettype none
module text_console_cursor_control #(
  parameter int unsigned TAB_STOP = tcc_pkg::TAB_STOP_DEFAULT
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tcc_in_if.sink   in_if,
  tcc_out_if.source out_if,
  tcc_cfg_if.sink  cfg_if
);
  import tcc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  tcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_action_i (in_if.action),
    .in_ready_o  (in_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcc_dp #(
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_if.valid),
    .cfg_index_i       (cfg_if.index),
    .cfg_data_i        (cfg_if.data),
    .in_char_code_i    (in_if.char_code),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_if.valid),
    .out_ready_i       (out_if.ready),
    .out_command_o     (out_if.command),
    .out_cell_column_o (out_if.cell_column),
    .out_cell_row_o    (out_if.cell_row),
    .out_glyph_code_o  (out_if.glyph_code),
    .out_last_o        (out_if.last)
  );

endmodule
`default_nettype wire

@@ verif/tcc_cell_checker.sv @@
// Cursor predictor and cell command scoreboard for the text console cursor control block.
`timescale 1ns / 1ps
module tcc_cell_checker #(
  parameter int unsigned TAB_STOP = tcc_pkg::TAB_STOP_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcc_in_if          in_if,
  tcc_out_if         out_if,
  tcc_cfg_if         cfg_if,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import tcc_pkg::*;

  typedef struct packed {
    logic       command;
    logic [7:0] cell_column;
    logic [7:0] cell_row;
    logic [7:0] glyph_code;
    logic       last;
  } cell_cmd_t;

  logic [7:0]  text_cols;
  logic [7:0]  text_rows;
  logic [7:0]  cur_col;
  logic [7:0]  cur_row;
  cell_cmd_t   cells_due[$];
  cell_cmd_t   burst_q[$];
  int unsigned fails = 0;

  // One non-tab character: move the cursor, then wrap and clamp.
  function automatic void put_cell(input logic [7:0] code);
    int unsigned col;
    int unsigned row;
    int unsigned ncols;
    int unsigned nrows;
    col   = cur_col;
    row   = cur_row;
    ncols = (text_cols == 8'd0) ? 1 : text_cols;
    nrows = (text_rows == 8'd0) ? 1 : text_rows;
    case (code)
      CH_CR: col = 0;
      CH_LF: begin
        col = 0;
        row++;
      end
      CH_BS: if (col != 0) col--;
      default: begin
        burst_q.push_back('{CMD_DRAW, 8'(col), 8'(row), code, 1'b0});
        col++;
      end
    endcase
    if (col >= ncols) begin
      col = 0;
      row++;
    end
    if (row >= nrows) begin
      row = nrows - 1;
      burst_q.push_back('{CMD_SCROLL, 8'd0, 8'd0, 8'd0, 1'b0});
    end
    cur_col = 8'(col);
    cur_row = 8'(row);
  endfunction

  function automatic void predict_cells(input logic act, input logic [7:0] code);
    int unsigned spaces;
    burst_q.delete();
    if (act == ACT_HOME) begin
      cur_col = 8'd0;
      cur_row = 8'd0;
    end else if (code == CH_TAB) begin
      spaces = TAB_STOP - (cur_col % TAB_STOP);
      // drop the remaining spaces once two more beats could overflow the budget
      while (spaces > 0 && burst_q.size() + 2 <= MAX_RESULTS) begin
        put_cell(CH_SPACE);
        spaces--;
      end
    end else begin
      put_cell(code);
    end
    foreach (burst_q[i]) begin
      cell_cmd_t c;
      c = burst_q[i];
      c.last = (i == burst_q.size() - 1);
      cells_due.push_back(c);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    cell_cmd_t due;
    if (!rst_ni) begin
      text_cols = TEXT_COLUMNS_RESET;
      text_rows = TEXT_ROWS_RESET;
      cur_col   = 8'd0;
      cur_row   = 8'd0;
      cells_due.delete();
    end else begin
      // retire the output beat first: it belongs to an earlier input
      if (out_if.valid && out_if.ready) begin
        if (cells_due.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual cmd=%0d col=%0d row=%0d %s",
                   $time, out_if.command, out_if.cell_column, out_if.cell_row,
                   $sformatf("glyph=%0d last=%0d", out_if.glyph_code, out_if.last));
          fails++;
        end else begin
          due = cells_due.pop_front();
          check_field("command", 8'(due.command), 8'(out_if.command));
          check_field("cell_column", due.cell_column, out_if.cell_column);
          check_field("cell_row", due.cell_row, out_if.cell_row);
          check_field("glyph_code", due.glyph_code, out_if.glyph_code);
          check_field("last", 8'(due.last), 8'(out_if.last));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_TEXT_COLUMNS) text_cols = cfg_if.data;
        else text_rows = cfg_if.data;
      end
      if (in_if.valid && in_if.ready) predict_cells(in_if.action, in_if.char_code);
    end
    pending_o    <= cells_due.size();
    fail_count_o <= fails;
  end

endmodule

@@ verif/tb_text_console_cursor_control.sv @@
// Stimulus, handshake timing and verdict for the text console cursor control block.
`timescale 1ns / 1ps
module tb_text_console_cursor_control;
  import tcc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  bit          idle_on   = 1'b1;
  bit          long_hold = 1'b0;
  int unsigned pending;
  int unsigned fail_count;

  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();
  tcc_cfg_if cfg_ch ();

  text_console_cursor_control uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  tcc_cell_checker cell_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_if      (cfg_ch),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("** text_console_cursor_control: FAILED **");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int unsigned span;
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        span = 120;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        span = $urandom_range(1, 4);
      end else begin
        out_ch.ready <= 1'b1;
        span = $urandom_range(1, 8);
      end
      repeat (span) @(posedge clk_i);
    end
  end

  task automatic offer_char(input logic act, input logic [7:0] code);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.char_code <= code;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Drop valid, wait for every outstanding beat, then let the block settle.
  task automatic drain_results(input int unsigned settle);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_TEXT_COLUMNS;
    cfg_ch.data  <= cols;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.index <= REG_TEXT_ROWS;
    cfg_ch.data  <= rows;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [8:0] pick_item();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return {ACT_HOME, 8'($urandom)};
    if (roll < 22) return {ACT_PUT, CH_TAB};
    if (roll < 32) return {ACT_PUT, CH_LF};
    if (roll < 37) return {ACT_PUT, CH_CR};
    if (roll < 45) return {ACT_PUT, CH_BS};
    return {ACT_PUT, 8'($urandom)};
  endfunction

  initial begin
    logic [8:0] item;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_PUT;
    in_ch.char_code = 8'd0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_TEXT_COLUMNS;
    cfg_ch.data     = 8'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset geometry: printable and blank-cell codes, cursor controls, tabs
    offer_char(ACT_PUT, 8'h41);
    offer_char(ACT_PUT, 8'h00);
    offer_char(ACT_PUT, 8'hff);
    offer_char(ACT_PUT, 8'h7f);
    offer_char(ACT_PUT, 8'h80);
    offer_char(ACT_PUT, CH_BS);
    offer_char(ACT_PUT, CH_TAB);
    offer_char(ACT_PUT, CH_CR);
    offer_char(ACT_PUT, CH_BS);
    offer_char(ACT_PUT, CH_LF);
    offer_char(ACT_PUT, CH_TAB);
    offer_char(ACT_HOME, 8'h41);
    offer_char(ACT_PUT, 8'h20);
    drain_results(8);

    // zero-sized area acts as one cell: every space wraps and scrolls
    set_geometry(8'd0, 8'd0);
    offer_char(ACT_PUT, 8'h55);
    offer_char(ACT_PUT, CH_TAB);
    offer_char(ACT_PUT, CH_LF);
    offer_char(ACT_PUT, CH_BS);
    offer_char(ACT_PUT, CH_CR);
    drain_results(8);

    // move the cursor far out, then shrink the area under it
    set_geometry(8'd255, 8'd255);
    offer_char(ACT_PUT, CH_TAB);
    offer_char(ACT_PUT, CH_TAB);
    offer_char(ACT_PUT, CH_LF);
    offer_char(ACT_PUT, CH_TAB);
    offer_char(ACT_PUT, CH_TAB);
    drain_results(8);
    set_geometry(8'd3, 8'd1);
    offer_char(ACT_PUT, 8'h5a);
    offer_char(ACT_PUT, CH_TAB);
    drain_results(8);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_geometry(8'd255, 8'd255);
        1: begin
          set_geometry(8'($urandom_range(1, 12)), 8'($urandom_range(1, 5)));
          long_hold = 1'b1;
        end
        2: set_geometry(8'd0, 8'($urandom_range(0, 3)));
        3: set_geometry(8'($urandom), 8'($urandom));
        default: begin
          idle_on = 1'b0;
          set_geometry(TEXT_COLUMNS_RESET, TEXT_ROWS_RESET);
        end
      endcase
      repeat (39) begin
        item = pick_item();
        offer_char(item[8], item[7:0]);
      end
      drain_results(8);
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** text_console_cursor_control: PASSED **");
    end else begin
      $display("** text_console_cursor_control: FAILED **");
    end
    $finish;
  end

endmodule

@@ text_console_cursor_control.f @@
sv/tcc_pkg.sv
sv/tcc_intf.sv
sv/tcc_ctrl.sv
sv/tcc_dp.sv
sv/text_console_cursor_control.sv
verif/tcc_cell_checker.sv
verif/tb_text_console_cursor_control.sv
